// ===== rtl/core/mqsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and constants for the multi-queue shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  localparam int unsigned MQSB_ENTRIES    = 16;
  localparam int unsigned MQSB_QUEUES     = 4;
  localparam int unsigned MQSB_DATA_WIDTH = 32;

  localparam int unsigned MQSB_BUS_WIDTH  = 32;
  localparam int unsigned MQSB_QID_WIDTH  = 2;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mqsb_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } mqsb_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_BUSY = 1'b1
  } mqsb_state_e;

endpackage

// ===== rtl/core/mqsb_ram.sv =====
// ----------------------------------------------------------------------------
// mqsb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mqsb_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/multi_queue_shared_buffer_core.sv =====
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_core
// Several FIFO queues as linked lists in one payload RAM, with a free list.
// ----------------------------------------------------------------------------
// An input transfer moves the block from idle to busy; it takes no new item while busy.
// Busy ends once the output is free, registering the result and the link RAM update.
// A full output register holds the pending item until the result is taken.
// Reset: asynchronous; all queues empty, free list runs through every slot in order.
// Link RAM needs no clearing pass: slots never allocated are tracked by a fill count.
module multi_queue_shared_buffer_core #(
  parameter int unsigned ENTRIES    = mqsb_pkg::MQSB_ENTRIES,
  parameter int unsigned QUEUES     = mqsb_pkg::MQSB_QUEUES,
  parameter int unsigned DATA_WIDTH = mqsb_pkg::MQSB_DATA_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mqsb_pkg::MQSB_BUS_WIDTH-1:0] s_axis_tdata,   // data_in
  input  logic [mqsb_pkg::MQSB_QID_WIDTH:0]   s_axis_tuser,   // mode, queue_id
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mqsb_pkg::MQSB_BUS_WIDTH-1:0] m_axis_tdata,   // data_out
  output logic [1:0]                          m_axis_tuser    // status
);

  import mqsb_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned PW = $clog2(ENTRIES + 1);
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  mqsb_state_e state_q, state_d;

  logic [PW-1:0] head_q [QUEUES];
  logic [PW-1:0] head_d [QUEUES];
  logic [AW-1:0] tail_q [QUEUES];
  logic [AW-1:0] tail_d [QUEUES];
  logic [PW-1:0] free_head_q, free_head_d;
  logic [PW-1:0] fresh_q, fresh_d;

  mqsb_mode_e          op_mode_q;
  logic [QW-1:0]       op_qidx_q;
  logic                op_ok_q;
  logic                op_empty_q;
  logic                op_fresh_q;
  logic [AW-1:0]       op_slot_q;
  logic [DATA_WIDTH-1:0] op_data_q;

  logic                      out_valid_q, out_valid_d;
  logic [MQSB_BUS_WIDTH-1:0] out_data_q, out_data_d;
  mqsb_status_e              out_status_q, out_status_d;

  mqsb_mode_e    in_mode;
  logic          in_qok;
  logic [QW-1:0] in_qidx;
  logic [PW-1:0] in_head;
  logic          in_ok;
  logic [AW-1:0] in_slot;
  logic          in_xfer;
  logic          done;

  logic                  link_we;
  logic [AW-1:0]         link_waddr;
  logic [PW-1:0]         link_wdata;
  logic [PW-1:0]         link_rdata;
  logic                  pay_we;
  logic [DATA_WIDTH-1:0] pay_rdata;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_mode       = mqsb_mode_e'(s_axis_tuser[0]);
  assign in_qok        = 32'(s_axis_tuser[MQSB_QID_WIDTH:1]) < QUEUES;
  assign in_qidx       = in_qok ? QW'(s_axis_tuser[MQSB_QID_WIDTH:1]) : '0;
  assign in_head       = head_q[in_qidx];

  always_comb begin
    if (in_mode == MODE_ENQ) begin
      in_ok   = in_qok && (free_head_q != NIL);
      in_slot = free_head_q[AW-1:0];
    end else begin
      in_ok   = in_qok && (in_head != NIL);
      in_slot = in_head[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_mode_q  <= in_mode;
      op_qidx_q  <= in_qidx;
      op_ok_q    <= in_ok;
      op_empty_q <= (in_head == NIL);
      op_fresh_q <= (free_head_q >= fresh_q);
      op_slot_q  <= in_slot;
      op_data_q  <= DATA_WIDTH'(s_axis_tdata);
    end
  end

  assign done = (state_q == S_BUSY) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_head_d  = free_head_q;
    fresh_d      = fresh_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    link_we      = 1'b0;
    link_waddr   = op_slot_q;
    link_wdata   = free_head_q;
    pay_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (done) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_data_d  = '0;
          if (!op_ok_q) begin
            out_status_d = (op_mode_q == MODE_ENQ) ? STATUS_OVERFLOW : STATUS_UNDERFLOW;
          end else if (op_mode_q == MODE_ENQ) begin
            out_status_d = STATUS_OK;
            pay_we       = 1'b1;
            free_head_d  = op_fresh_q ? (PW'(op_slot_q) + PW'(1)) : link_rdata;
            fresh_d      = op_fresh_q ? (fresh_q + PW'(1)) : fresh_q;
            tail_d[op_qidx_q] = op_slot_q;
            if (op_empty_q) begin
              head_d[op_qidx_q] = PW'(op_slot_q);
            end else begin
              link_we    = 1'b1;
              link_waddr = tail_q[op_qidx_q];
              link_wdata = PW'(op_slot_q);
            end
          end else begin
            out_status_d = STATUS_OK;
            out_data_d   = MQSB_BUS_WIDTH'(pay_rdata);
            head_d[op_qidx_q] = (op_slot_q == tail_q[op_qidx_q]) ? NIL : link_rdata;
            link_we      = 1'b1;
            link_waddr   = op_slot_q;
            link_wdata   = free_head_q;
            free_head_d  = PW'(op_slot_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= NIL;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q       <= tail_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  mqsb_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (PW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (in_xfer),
    .raddr_i (in_slot),
    .rdata_o (link_rdata)
  );

  mqsb_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (DATA_WIDTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (op_slot_q),
    .wdata_i (op_data_q),
    .re_i    (in_xfer),
    .raddr_i (in_slot),
    .rdata_o (pay_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// ===== rtl/core/mqsb_checker.sv =====
// ----------------------------------------------------------------------------
// mqsb_checker
// Port-level checks on the multi-queue shared buffer, bound to the top level.
// ----------------------------------------------------------------------------
module mqsb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [mqsb_pkg::MQSB_BUS_WIDTH-1:0] s_axis_tdata,
  input logic [mqsb_pkg::MQSB_QID_WIDTH:0]   s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [mqsb_pkg::MQSB_BUS_WIDTH-1:0] m_axis_tdata,
  input logic [1:0]                          m_axis_tuser
);

  import mqsb_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
    else $error("nonzero data on overflow or underflow");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !m_axis_tvalid |-> ##2 m_axis_tvalid)
    else $error("result missing two cycles after input transfer");

endmodule

bind multi_queue_shared_buffer_core mqsb_checker u_mqsb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/multi_queue_shared_buffer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_core_test
// Self-checking bench for the linked-list queues in one shared payload buffer.
// Streams enqueue and dequeue operations into the block and tracks every
// queue, the free list and the slot payloads in a scoreboard. Each returned
// word and status is checked against the oldest predicted result. The sender
// idles in bursts and the receiver stalls, once for a long stretch.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_core_test;
  import mqsb_pkg::*;

  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS = 625;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned SLOT_W       = $clog2(MQSB_ENTRIES + 1);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [MQSB_BUS_WIDTH-1:0] data;
    mqsb_status_e              status;
  } op_result_t;

  class shared_buffer_scoreboard;
    slot_t                      link_mem    [MQSB_ENTRIES];
    logic [MQSB_DATA_WIDTH-1:0] payload_mem [MQSB_ENTRIES];
    slot_t                      head        [MQSB_QUEUES];
    slot_t                      tail        [MQSB_QUEUES];
    slot_t                      free_head;
    op_result_t                 pending_results [$];
    int unsigned                errors;
    int unsigned                checked;

    function new();
      for (int i = 0; i < MQSB_ENTRIES; i++) begin
        link_mem[i]    = slot_t'(i + 1);
        payload_mem[i] = '0;
      end
      for (int q = 0; q < MQSB_QUEUES; q++) begin
        head[q] = slot_t'(MQSB_ENTRIES);
        tail[q] = slot_t'(MQSB_ENTRIES);
      end
      free_head = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function bit is_slot(slot_t p);
      return p < MQSB_ENTRIES;
    endfunction

    function void note_transfer(mqsb_mode_e mode, logic [MQSB_QID_WIDTH-1:0] qid,
                                logic [MQSB_BUS_WIDTH-1:0] data);
      op_result_t res;
      slot_t      slot;
      res.data   = '0;
      res.status = STATUS_OK;
      if (mode == MODE_ENQ) begin
        if (qid >= MQSB_QUEUES || !is_slot(free_head)) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          slot      = free_head;
          free_head = link_mem[slot];
          if (!is_slot(head[qid])) begin
            head[qid] = slot;
          end else if (is_slot(tail[qid])) begin
            link_mem[tail[qid]] = slot;
          end
          link_mem[slot]    = slot_t'(MQSB_ENTRIES);
          tail[qid]         = slot;
          payload_mem[slot] = data[MQSB_DATA_WIDTH-1:0];
        end
      end else begin
        if (qid >= MQSB_QUEUES || !is_slot(head[qid])) begin
          res.status = STATUS_UNDERFLOW;
        end else begin
          slot           = head[qid];
          head[qid]      = link_mem[slot];
          link_mem[slot] = free_head;
          free_head      = slot;
          res.data       = MQSB_BUS_WIDTH'(payload_mem[slot]);
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [MQSB_BUS_WIDTH-1:0] data, logic [1:0] status);
      op_result_t exp_res;
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result %0d: unexpected, data %h status %0d", checked, data, status);
        return;
      end
      exp_res = pending_results.pop_front();
      if (data !== exp_res.data || status !== exp_res.status) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result %0d: expected data %h status %0d, got data %h status %0d",
                   checked, exp_res.data, exp_res.status, data, status);
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [MQSB_BUS_WIDTH-1:0] s_axis_tdata;   // data_in
  logic [MQSB_QID_WIDTH:0]   s_axis_tuser;   // mode, queue_id
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [MQSB_BUS_WIDTH-1:0] m_axis_tdata;   // data_out
  logic [1:0]                m_axis_tuser;   // status

  shared_buffer_scoreboard sb;
  int unsigned             burst_left = 0;
  int unsigned             quiet_cycles = 0;

  multi_queue_shared_buffer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic issue_item(mqsb_mode_e mode, logic [MQSB_QID_WIDTH-1:0] qid,
                            logic [MQSB_BUS_WIDTH-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= {qid, mode};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      sb.note_transfer(mqsb_mode_e'(s_axis_tuser[0]), s_axis_tuser[MQSB_QID_WIDTH:1],
                       s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned seg_len;
    int unsigned kind;
    int unsigned seg_idx;
    seg_idx = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      seg_len = $urandom_range(10, 60);
      kind    = $urandom_range(0, 2);
      if (seg_idx == 3) begin
        // hold off long enough for the held result to stall the block's input
        for (int i = 0; i < LONG_HOLD; i++) begin
          @(posedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end else begin
        for (int i = 0; i < seg_len; i++) begin
          @(posedge clk_i);
          case (kind)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= (i % 4 == 3);
          endcase
        end
      end
      seg_idx++;
    end
  end

  initial begin
    logic [MQSB_BUS_WIDTH-1:0] corner [8];
    int unsigned               enq_pct;
    mqsb_mode_e                mode;
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
               32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE};
    enq_pct = 50;
    sb = new();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // underflow on empty queues, fill every slot, overflow, drain one queue and
    // underflow it once more, then refill it past its stale tail
    issue_item(MODE_DEQ, 2'd0, 32'h0000_0000);
    issue_item(MODE_DEQ, 2'd3, 32'hFFFF_FFFF);
    for (int i = 0; i < MQSB_ENTRIES; i++)
      issue_item(MODE_ENQ, 2'(i % MQSB_QUEUES), (i < 8) ? corner[i] : $urandom);
    issue_item(MODE_ENQ, 2'd2, 32'h1234_5678);
    repeat (MQSB_ENTRIES / MQSB_QUEUES) issue_item(MODE_DEQ, 2'd1, 32'h0000_0000);
    issue_item(MODE_DEQ, 2'd1, 32'h0000_0000);
    issue_item(MODE_ENQ, 2'd1, $urandom);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 85;
          1:       enq_pct = 15;
          default: enq_pct = 55;
        endcase
      end
      mode = ($urandom_range(1, 100) <= enq_pct) ? MODE_ENQ : MODE_DEQ;
      issue_item(mode, 2'($urandom_range(0, MQSB_QUEUES - 1)), $urandom);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mqsb_pkg.sv
rtl/core/mqsb_ram.sv
rtl/core/multi_queue_shared_buffer_core.sv
rtl/core/mqsb_checker.sv
sim/multi_queue_shared_buffer_core_test.sv
